// ===== hw/rtl/psb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and fixed field widths for the packet slot buffer.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int NODE_W  = 48;
  localparam int CC_W    = 8;
  localparam int LEN_W   = 16;
  localparam int SEQ_W   = 32;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int PSIZE_W = 10;
  localparam int ERR_W   = 32;
  localparam int OCC_W   = 7;

  // 30-byte header plus the 4-byte sequence word
  localparam int OVERHEAD_BYTES = 34;

  localparam logic REQ_RECEIVE = 1'b0;
  localparam logic REQ_FETCH   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_OWN       = 3'd1,
    ST_BAD       = 3'd2,
    ST_FULL      = 3'd3,
    ST_DELIVERED = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_TRIM
  } state_t;

  typedef struct packed {
    logic                    req_type;
    logic [CC_W-1:0]         cmpl_code;
    logic [NODE_W-1:0]       source_node;
    logic [LEN_W-1:0]        packet_length;
    logic signed [SEQ_W-1:0] sequence_number;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_W-1:0]       slot_index;
    logic [PSIZE_W-1:0]      payload_size;
    logic signed [SEQ_W-1:0] sequence_out;
    logic [ERR_W-1:0]        error_count;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [SEQ_W-1:0] seq;
    logic [PSIZE_W-1:0]      size;
  } slot_entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface psb_in_if;
  logic               valid;
  logic               ready;
  psb_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psb_out_if;
  logic               valid;
  logic               ready;
  psb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/psb_slot_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_slot_mem
// Per-slot sequence number and payload size, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module psb_slot_mem #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  psb_pkg::slot_entry_t       wr_data,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr,
  output psb_pkg::slot_entry_t       rd_data
);
  import psb_pkg::*;

  slot_entry_t mem_r [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/psb_free_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_free_stack
// Free-slot stack memory; an entry never written reads as its own index.
// ----------------------------------------------------------------------------
module psb_free_stack #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  logic [$clog2(SLOTS)-1:0]   wr_data,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr,
  output logic [$clog2(SLOTS)-1:0]   rd_data
);
  localparam int IDX_W = $clog2(SLOTS);

  logic [IDX_W-1:0] mem_r [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [IDX_W-1:0] rd_mem_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_mem_r  <= mem_r[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    rd_addr_r <= rd_addr;
  end

  assign rd_data = rd_vld_r ? rd_mem_r : rd_addr_r;

endmodule
`default_nettype wire

// ===== hw/rtl/psb_min_track.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_min_track
// Shared compare unit: keeps the lowest sequence seen during a scan,
// first slot wins on a tie.
// ----------------------------------------------------------------------------
module psb_min_track #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       cand_live,
  input  logic [$clog2(SLOTS)-1:0]   cand_idx,
  input  psb_pkg::slot_entry_t       cand,
  output logic                       found,
  output logic [$clog2(SLOTS)-1:0]   best_idx,
  output psb_pkg::slot_entry_t       best
);
  import psb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  slot_entry_t      best_r, best_nxt;
  logic             lower;

  assign lower = $signed(cand.seq) < $signed(best_r.seq);

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    if (clear) begin
      found_nxt = 1'b0;
    end else if (cand_live && (!found_r || lower)) begin
      found_nxt = 1'b1;
      idx_nxt   = cand_idx;
      best_nxt  = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end

  assign found    = found_r;
  assign best_idx = idx_r;
  assign best     = best_r;

endmodule
`default_nettype wire

// ===== hw/rtl/packet_slot_buffer_min_sequence.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_slot_buffer_min_sequence
// Receive: turned away straight from idle, or stored via S_POP (free-stack
// read). Fetch: S_SCAN, one slot read per cycle through the slot memory port
// up to highest_slot; S_DRAIN, S_DECIDE, then S_TRIM if the high mark must fall.
// One transaction at a time; ready again once the result is taken.
// Synchronous reset, no clearing pass: valid bits and counters clear at once.
// ----------------------------------------------------------------------------
module packet_slot_buffer_min_sequence #(
  parameter int SLOTS       = 64,
  parameter int MAX_PAYLOAD = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  psb_in_if.sink                      in_ch,
  psb_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [psb_pkg::NODE_W-1:0]  cfg_wdata
);
  import psb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   own_r, own_nxt;
  logic [SLOTS-1:0]    slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]    hi_r, hi_nxt;
  logic [ERR_W-1:0]    rej_r, rej_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic signed [SEQ_W-1:0] pend_seq_r, pend_seq_nxt;
  logic [PSIZE_W-1:0]  pend_size_r, pend_size_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                cmp_live_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;

  in_item_t            req;
  logic                accept;
  logic [LEN_W-1:0]    pay_len;
  logic                len_bad;
  logic                full;
  logic                rx_ok;
  logic [ERR_W-1:0]    rej_inc;
  logic [CNT_W-1:0]    used_dec;
  logic [IDX_W-1:0]    hi_dec;
  logic                trim_done;
  logic                finish;

  logic                mem_we;
  slot_entry_t         mem_wdata;
  slot_entry_t         mem_rdata;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [IDX_W-1:0]    stk_raddr;
  logic [IDX_W-1:0]    stk_rdata;
  logic                min_clear;
  logic                found;
  logic [IDX_W-1:0]    best_idx;
  slot_entry_t         best;

  assign req     = in_ch.data;
  assign accept  = in_ch.valid && in_ch.ready;
  assign pay_len = req.packet_length - LEN_W'(OVERHEAD_BYTES);
  assign len_bad = (req.packet_length < LEN_W'(OVERHEAD_BYTES))
                || (pay_len > LEN_W'(MAX_PAYLOAD));
  assign full    = used_r >= CNT_W'(SLOTS);
  assign rx_ok   = (req.cmpl_code == '0) && (req.source_node != own_r)
                && !len_bad && !full && !req.sequence_number[SEQ_W-1];
  assign rej_inc = rej_r + ERR_W'(1);
  assign used_dec  = (used_r != '0) ? used_r - CNT_W'(1) : used_r;
  assign hi_dec    = hi_r - IDX_W'(1);
  assign trim_done = (hi_dec == '0) || slot_valid_r[hi_dec];

  assign stk_raddr = full ? '0 : used_r[IDX_W-1:0];
  assign min_clear = accept && (req.req_type == REQ_FETCH);
  assign mem_wdata = '{seq: pend_seq_r, size: pend_size_r};

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  psb_slot_mem #(.SLOTS(SLOTS)) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (stk_rdata),
    .wr_data (mem_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (mem_rdata)
  );

  psb_free_stack #(.SLOTS(SLOTS)) u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (best_idx),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  psb_min_track #(.SLOTS(SLOTS)) u_min_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (min_clear),
    .cand_live (cmp_live_r && cmp_vld_r),
    .cand_idx  (cmp_idx_r),
    .cand      (mem_rdata),
    .found     (found),
    .best_idx  (best_idx),
    .best      (best)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_FETCH) begin
            state_nxt = S_SCAN;
          end else if (rx_ok) begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_idx_r == hi_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (found && (hi_r == best_idx) && (hi_r != '0)) begin
          state_nxt = S_TRIM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TRIM: begin
        if (trim_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    own_nxt        = cfg_we ? cfg_wdata : own_r;
    slot_valid_nxt = slot_valid_r;
    used_nxt       = used_r;
    hi_nxt         = hi_r;
    rej_nxt        = rej_r;
    scan_idx_nxt   = scan_idx_r;
    pend_seq_nxt   = pend_seq_r;
    pend_size_nxt  = pend_size_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    stk_we         = 1'b0;
    stk_waddr      = used_dec[IDX_W-1:0];
    finish         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.slot_index   = '0;
          out_nxt.payload_size = '0;
          out_nxt.sequence_out = '0;
          out_nxt.error_count  = rej_r;
          out_nxt.occupancy    = OCC_W'(used_r);
          if (req.req_type == REQ_FETCH) begin
            scan_idx_nxt = '0;
          end else if (req.cmpl_code != '0) begin
            rej_nxt             = rej_inc;
            out_nxt.status      = ST_BAD;
            out_nxt.error_count = rej_inc;
            finish              = 1'b1;
          end else if (req.source_node == own_r) begin
            out_nxt.status = ST_OWN;
            finish         = 1'b1;
          end else if (len_bad) begin
            rej_nxt             = rej_inc;
            out_nxt.status      = ST_BAD;
            out_nxt.error_count = rej_inc;
            finish              = 1'b1;
          end else if (full) begin
            rej_nxt             = rej_inc;
            out_nxt.status      = ST_FULL;
            out_nxt.error_count = rej_inc;
            finish              = 1'b1;
          end else if (req.sequence_number[SEQ_W-1]) begin
            rej_nxt             = rej_inc;
            out_nxt.status      = ST_BAD;
            out_nxt.error_count = rej_inc;
            finish              = 1'b1;
          end else begin
            pend_seq_nxt  = req.sequence_number;
            pend_size_nxt = pay_len[PSIZE_W-1:0];
          end
        end
      end
      S_POP: begin
        mem_we                    = 1'b1;
        slot_valid_nxt[stk_rdata] = 1'b1;
        used_nxt                  = used_r + CNT_W'(1);
        if (stk_rdata > hi_r) begin
          hi_nxt = stk_rdata;
        end
        out_nxt.status       = ST_STORED;
        out_nxt.slot_index   = SLOT_W'(stk_rdata);
        out_nxt.payload_size = pend_size_r;
        out_nxt.occupancy    = OCC_W'(used_r + CNT_W'(1));
        finish               = 1'b1;
      end
      S_SCAN: begin
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
      end
      S_DECIDE: begin
        if (!found) begin
          out_nxt.status = ST_EMPTY;
          finish         = 1'b1;
        end else begin
          slot_valid_nxt[best_idx] = 1'b0;
          used_nxt                 = used_dec;
          stk_we                   = 1'b1;
          out_nxt.status           = ST_DELIVERED;
          out_nxt.slot_index       = SLOT_W'(best_idx);
          out_nxt.payload_size     = best.size;
          out_nxt.sequence_out     = best.seq;
          out_nxt.occupancy        = OCC_W'(used_dec);
          if (!((hi_r == best_idx) && (hi_r != '0))) begin
            finish = 1'b1;
          end
        end
      end
      S_TRIM: begin
        hi_nxt = hi_dec;
        finish = trim_done;
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      own_r        <= '0;
      slot_valid_r <= '0;
      used_r       <= '0;
      hi_r         <= '0;
      rej_r        <= '0;
      out_valid_r  <= 1'b0;
      cmp_live_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      own_r        <= own_nxt;
      slot_valid_r <= slot_valid_nxt;
      used_r       <= used_nxt;
      hi_r         <= hi_nxt;
      rej_r        <= rej_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_live_r   <= (state_r == S_SCAN);
    end
    scan_idx_r  <= scan_idx_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_size_r <= pend_size_nxt;
    out_r       <= out_nxt;
    cmp_vld_r   <= slot_valid_r[scan_idx_r];
    cmp_idx_r   <= scan_idx_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/psb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psb_checker
// Port-level checks on the packet slot buffer, bound to the top level.
// ----------------------------------------------------------------------------
module psb_checker #(
  parameter int SLOTS = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input psb_pkg::status_t            out_status,
  input logic [psb_pkg::SLOT_W-1:0]  out_slot_index,
  input logic [psb_pkg::OCC_W-1:0]   out_occupancy
);
  import psb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot_index) && $stable(out_occupancy))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a transaction is in progress");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while a result is pending");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_occupancy == '0) && (out_slot_index == '0) && (SLOTS > 0))
    else $error("empty fetch with slots in use");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind packet_slot_buffer_min_sequence psb_checker #(.SLOTS(SLOTS)) u_psb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.data.status),
  .out_slot_index (out_ch.data.slot_index),
  .out_occupancy  (out_ch.data.occupancy)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Packet slot buffer testbench
// Drives receive and fetch transactions into the slot buffer, keeps its own
// slot table, free stack and counters, and checks every result transaction
// field by field. Both channels idle at random; one stretch holds the result
// side off so that the buffer stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psb_pkg::*;

  localparam int SLOTS       = 64;
  localparam int MAX_PAYLOAD = 512;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [NODE_W-1:0] cfg_wdata;

  psb_in_if  in_ch();
  psb_out_if out_ch();

  packet_slot_buffer_min_sequence #(
    .SLOTS       (SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // buffer state as the testbench sees it
  logic [NODE_W-1:0]       own_node;
  bit                      slot_used [SLOTS];
  logic signed [SEQ_W-1:0] slot_seq [SLOTS];
  logic [PSIZE_W-1:0]      slot_bytes [SLOTS];
  logic [SLOT_W-1:0]       free_list [SLOTS];
  int                      stored_count;
  int                      high_mark;
  logic [ERR_W-1:0]        reject_total;

  out_item_t pending_results[$];
  int        failures;
  bit        in_idle_on;
  bit        out_idle_on;
  int        result_stall;
  int        receiver_hold;

  function automatic out_item_t buffer_response(input in_item_t req);
    out_item_t rsp;
    int        len;
    int        pick;
    bit        found;
    rsp = '0;
    len = req.packet_length;
    if (req.req_type == REQ_RECEIVE) begin
      if (req.cmpl_code != '0) begin
        reject_total++;
        rsp.status = ST_BAD;
      end else if (req.source_node == own_node) begin
        rsp.status = ST_OWN;
      end else if (len < OVERHEAD_BYTES || len - OVERHEAD_BYTES > MAX_PAYLOAD) begin
        reject_total++;
        rsp.status = ST_BAD;
      end else if (stored_count >= SLOTS) begin
        reject_total++;
        rsp.status = ST_FULL;
      end else if (req.sequence_number[SEQ_W-1]) begin
        reject_total++;
        rsp.status = ST_BAD;
      end else begin
        pick = free_list[stored_count];
        stored_count++;
        if (pick > high_mark) high_mark = pick;
        slot_used[pick]  = 1'b1;
        slot_seq[pick]   = req.sequence_number;
        slot_bytes[pick] = PSIZE_W'(len - OVERHEAD_BYTES);
        rsp.status       = ST_STORED;
        rsp.slot_index   = SLOT_W'(pick);
        rsp.payload_size = slot_bytes[pick];
      end
    end else begin
      found = 1'b0;
      pick  = 0;
      for (int i = 0; i <= high_mark; i++) begin
        if (slot_used[i] && (!found || slot_seq[i] < slot_seq[pick])) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (!found) begin
        rsp.status = ST_EMPTY;
      end else begin
        slot_used[pick] = 1'b0;
        if (stored_count > 0) stored_count--;
        free_list[stored_count % SLOTS] = SLOT_W'(pick);
        if (high_mark == pick) begin
          while (high_mark > 0) begin
            high_mark--;
            if (high_mark == 0 || slot_used[high_mark]) break;
          end
        end
        rsp.status       = ST_DELIVERED;
        rsp.slot_index   = SLOT_W'(pick);
        rsp.payload_size = slot_bytes[pick];
        rsp.sequence_out = slot_seq[pick];
      end
    end
    rsp.error_count = reject_total;
    rsp.occupancy   = OCC_W'(stored_count);
    return rsp;
  endfunction

  function automatic in_item_t receive_item(input logic [CC_W-1:0] cc,
                                            input logic [NODE_W-1:0] src,
                                            input logic [LEN_W-1:0] len,
                                            input logic [SEQ_W-1:0] seq);
    in_item_t p;
    p.req_type        = REQ_RECEIVE;
    p.cmpl_code       = cc;
    p.source_node     = src;
    p.packet_length   = len;
    p.sequence_number = seq;
    return p;
  endfunction

  function automatic in_item_t fetch_request();
    in_item_t p;
    p.req_type        = REQ_FETCH;
    p.cmpl_code       = CC_W'($urandom);
    p.source_node     = {16'($urandom), $urandom};
    p.packet_length   = LEN_W'($urandom);
    p.sequence_number = $urandom;
    return p;
  endfunction

  function automatic in_item_t good_packet(input bit narrow_seq);
    in_item_t p;
    p.req_type        = REQ_RECEIVE;
    p.cmpl_code       = '0;
    p.source_node     = {16'($urandom), $urandom};
    if (p.source_node == own_node) p.source_node[0] = ~p.source_node[0];
    case ($urandom_range(9, 0))
      0:       p.packet_length = LEN_W'(OVERHEAD_BYTES);
      1:       p.packet_length = LEN_W'(OVERHEAD_BYTES + MAX_PAYLOAD);
      default: p.packet_length = LEN_W'(OVERHEAD_BYTES + $urandom_range(MAX_PAYLOAD, 0));
    endcase
    if (narrow_seq) p.sequence_number = $urandom_range(7, 0);
    else if ($urandom_range(9, 0) == 0) p.sequence_number = 32'h7FFF_FFFF;
    else p.sequence_number = {1'b0, 31'($urandom)};
    return p;
  endfunction

  function automatic in_item_t noisy_packet();
    in_item_t p;
    p = good_packet(1'b0);
    case ($urandom_range(4, 0))
      0: p.cmpl_code = CC_W'($urandom_range(255, 1));
      1: p.source_node = own_node;
      2: begin
        if ($urandom_range(1, 0) == 0) begin
          p.packet_length = LEN_W'($urandom_range(OVERHEAD_BYTES - 1, 0));
        end else begin
          p.packet_length = LEN_W'($urandom_range(65535, OVERHEAD_BYTES + MAX_PAYLOAD + 1));
        end
      end
      3: p.sequence_number = {1'b1, 31'($urandom)};
      default: begin
        p.cmpl_code       = CC_W'($urandom);
        p.packet_length   = LEN_W'($urandom);
        p.sequence_number = $urandom;
      end
    endcase
    return p;
  endfunction

  function automatic in_item_t mixed_request(input int store_pct, input int fetch_pct,
                                             input bit narrow_seq);
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < store_pct) return good_packet(narrow_seq);
    if (roll < store_pct + fetch_pct) return fetch_request();
    return noisy_packet();
  endfunction

  task automatic send_request(input in_item_t item);
    int gap;
    gap = in_idle_on ? $urandom_range(7, 0) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = item;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(buffer_response(item));
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_own_node(input logic [NODE_W-1:0] node);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = node;
    own_node  = node;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed();
    send_request(fetch_request());
    send_request(receive_item(8'hFF, '0, 16'd100, 32'd1));
    send_request(receive_item(8'h00, '0, 16'd0, 32'd1));
    send_request(receive_item(8'h01, '1, 16'd100, 32'd1));
    send_request(receive_item(8'h00, '1, 16'd0, 32'd1));
    send_request(receive_item(8'h00, '1, 16'd33, 32'd1));
    send_request(receive_item(8'h00, '1, 16'd547, 32'd1));
    send_request(receive_item(8'h00, '1, 16'hFFFF, 32'd1));
    send_request(receive_item(8'h00, '1, 16'd100, 32'hFFFF_FFFF));
    send_request(receive_item(8'h00, '1, 16'd100, 32'h8000_0000));
    send_request(receive_item(8'h00, '1, 16'd34, 32'h7FFF_FFFF));
    send_request(receive_item(8'h00, 48'h1, 16'd546, 32'd0));
    send_request(receive_item(8'h00, 48'hAAAA_AAAA_AAAA, 16'd100, 32'd5));
    send_request(receive_item(8'h00, 48'h5555_5555_5555, 16'd200, 32'd5));
    repeat (5) send_request(fetch_request());
  endtask

  task automatic test_fill_and_full();
    write_own_node('1);
    in_idle_on = 1'b0;
    repeat (SLOTS) send_request(good_packet(1'b0));
    send_request(receive_item(8'h00, '0, 16'd33, 32'd1));
    send_request(receive_item(8'h00, '0, 16'd100, 32'h8000_0000));
    send_request(receive_item(8'h80, '0, 16'd100, 32'd1));
    send_request(receive_item(8'h00, '1, 16'd100, 32'd1));
    send_request(good_packet(1'b0));
    in_idle_on  = 1'b1;
    out_idle_on = 1'b0;
    repeat (SLOTS + 2) send_request(fetch_request());
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    write_own_node({16'($urandom), $urandom});
    repeat (220) send_request(mixed_request(55, 20, 1'b0));
    write_own_node({16'($urandom), $urandom});
    in_idle_on = 1'b0;
    repeat (200) send_request(mixed_request(20, 65, 1'b0));
    in_idle_on = 1'b1;
    repeat (200) send_request(mixed_request(45, 45, 1'b1));
  endtask

  task automatic test_backpressure();
    write_own_node('0);
    in_idle_on = 1'b0;
    @(posedge clk);
    receiver_hold = 400;
    repeat (30) send_request(mixed_request(50, 30, 1'b0));
    in_idle_on = 1'b1;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        receiver_hold--;
        out_ch.ready = 1'b0;
      end else if (result_stall > 0) begin
        result_stall--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      result_stall = out_idle_on ? $urandom_range(7, 0) : 0;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, status %0d", got.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
          failures++;
        end
        if (got.payload_size !== want.payload_size) begin
          $error("payload_size: expected %0d, got %0d", want.payload_size, got.payload_size);
          failures++;
        end
        if (got.sequence_out !== want.sequence_out) begin
          $error("sequence_out: expected %0d, got %0d", want.sequence_out, got.sequence_out);
          failures++;
        end
        if (got.error_count !== want.error_count) begin
          $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
          failures++;
        end
        if (got.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
          failures++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    result_stall  = 0;
    receiver_hold = 0;
    failures      = 0;
    own_node      = '0;
    stored_count  = 0;
    high_mark     = 0;
    reject_total  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      free_list[i] = SLOT_W'(i);
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_full();
    test_random_traffic();
    test_backpressure();

    settle();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/psb_pkg.sv
hw/rtl/psb_if.sv
hw/rtl/psb_slot_mem.sv
hw/rtl/psb_free_stack.sv
hw/rtl/psb_min_track.sv
hw/rtl/packet_slot_buffer_min_sequence.sv
hw/rtl/psb_checker.sv
dv/testbench.sv
